// ===== sv/hed_pkg.sv =====
`timescale 1ns / 1ps

package hed_pkg;

	localparam int NUM_ENT    = 7;
	localparam int ENT_W      = 6;
	localparam int HOLD_DEPTH = 5;
	localparam int RES_MAX    = 6;

	localparam logic [7:0] LIMIT_MAX   = 8'd255;
	localparam logic [7:0] LIMIT_RESET = 8'd128;
	localparam logic [7:0] AMP         = 8'h26;
	localparam logic [NUM_ENT-1:0] LIVE_ALL = '1;

	// entity spellings, unused tail positions are zero
	localparam logic [7:0] ENT_TEXT [NUM_ENT][ENT_W] = '{
		'{"&", "n", "b", "s", "p", ";"},
		'{"&", "a", "m", "p", ";", 8'h00},
		'{"&", "l", "t", ";", 8'h00, 8'h00},
		'{"&", "g", "t", ";", 8'h00, 8'h00},
		'{"&", "q", "u", "o", "t", ";"},
		'{"&", "#", "3", "9", ";", 8'h00},
		'{"&", "#", "0", "3", "9", ";"}
	};

	localparam logic [2:0] ENT_LEN [NUM_ENT] = '{
		3'd6, 3'd5, 3'd4, 3'd4, 3'd6, 3'd5, 3'd6
	};

	localparam logic [7:0] ENT_REPL [NUM_ENT] = '{
		" ", "&", "<", ">", 8'h22, 8'h27, 8'h27
	};

	typedef struct packed {
		logic [2:0]         cnt;
		logic [NUM_ENT-1:0] live;
		logic [7:0]         emitted;
	} hed_state_t;

	typedef struct packed {
		logic [RES_MAX-1:0][7:0] bytes;
		logic [2:0]              cnt;
		logic                    has_byte;
		logic                    last;
	} hed_res_t;

endpackage

// ===== sv/hed_match.sv =====
`timescale 1ns / 1ps

module hed_match (
	input  hed_pkg::hed_state_t                  cur,
	input  logic [hed_pkg::HOLD_DEPTH-1:0][7:0]  held,
	input  logic [7:0]                           limit,
	input  logic [7:0]                           byte_in,
	input  logic                                 last_in,
	output hed_pkg::hed_state_t                  nxt,
	output logic                                 hold_wr,
	output logic [2:0]                           hold_idx,
	output hed_pkg::hed_res_t                    res
);
	import hed_pkg::*;

	logic [2:0]         h;
	logic [NUM_ENT-1:0] nm;
	logic               complete;
	logic [7:0]         repl;
	logic               is_amp;
	logic               pass;
	logic               cont;
	logic               brk;
	logic               start;
	logic [RES_MAX-1:0][7:0] lst;
	logic [2:0]         n;
	logic [7:0]         lim_eff;
	logic [7:0]         avail;
	logic [2:0]         k;

	always_comb begin
		h = cur.cnt;
		nm = '0;
		for (int p = 0; p < NUM_ENT; p++) begin
			if (cur.live[p] && (h < ENT_LEN[p]) && (ENT_TEXT[p][h] == byte_in))
				nm[p] = 1'b1;
		end
		complete = 1'b0;
		repl = '0;
		// lowest entity index wins
		for (int p = NUM_ENT - 1; p >= 0; p--) begin
			if (nm[p] && (ENT_LEN[p] == h + 3'd1)) begin
				complete = 1'b1;
				repl = ENT_REPL[p];
			end
		end
		is_amp = (byte_in == AMP);
		pass = !is_amp || last_in;
		cont = (h != 3'd0) && (nm != '0) && !complete && (h < 3'(HOLD_DEPTH));
		brk = (h != 3'd0) && !complete && !cont;
		start = !last_in && is_amp && ((h == 3'd0) || brk);

		// held bytes first, then the current byte
		for (int i = 0; i < RES_MAX; i++)
			lst[i] = byte_in;
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			if (3'(i) < h)
				lst[i] = held[i];
		end
		if (complete)
			lst[0] = repl;

		priority if (h == 3'd0) begin
			n = pass ? 3'd1 : 3'd0;
		end else if (complete) begin
			n = 3'd1;
		end else if (cont) begin
			n = last_in ? h + 3'd1 : 3'd0;
		end else begin
			n = pass ? h + 3'd1 : h;
		end

		lim_eff = (limit > LIMIT_MAX) ? LIMIT_MAX : limit;
		avail = (lim_eff > cur.emitted) ? lim_eff - cur.emitted - 8'd1 : 8'd0;
		k = ({5'd0, n} < avail) ? n : avail[2:0];

		res.bytes = lst;
		res.last = last_in;
		if (last_in && (k == 3'd0)) begin
			res.cnt = 3'd1;
			res.has_byte = 1'b0;
			res.bytes[0] = 8'h00;
		end else begin
			res.cnt = k;
			res.has_byte = 1'b1;
		end

		if (last_in) begin
			nxt.cnt = 3'd0;
			nxt.live = '0;
			nxt.emitted = 8'd0;
		end else begin
			nxt.emitted = cur.emitted + {5'd0, k};
			priority if (start) begin
				nxt.cnt = 3'd1;
				nxt.live = LIVE_ALL;
			end else if (cont) begin
				nxt.cnt = h + 3'd1;
				nxt.live = nm;
			end else begin
				nxt.cnt = 3'd0;
				nxt.live = '0;
			end
		end

		hold_wr = start || (cont && !last_in);
		hold_idx = cont ? h : 3'd0;
	end

endmodule

// ===== sv/hed_outbuf.sv =====
`timescale 1ns / 1ps

module hed_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hed_pkg::hed_res_t res,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              has_byte,
	output logic              out_last
);
	import hed_pkg::*;

	logic [RES_MAX-1:0][7:0] bytes_q;
	logic [2:0]              rem_q;
	logic                    has_q;
	logic                    last_q;
	logic                    pop;

	assign out_valid = (rem_q != 3'd0);
	assign pop = out_valid && out_ready;
	assign free = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_ready);
	assign out_byte = bytes_q[0];
	assign has_byte = has_q;
	assign out_last = last_q && (rem_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (load) begin
			rem_q <= res.cnt;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			has_q <= res.has_byte;
			last_q <= res.last;
		end else if (pop) begin
			bytes_q <= {8'h00, bytes_q[RES_MAX-1:1]};
		end
	end

endmodule

// ===== sv/html_entity_decoder_unit.sv =====
`timescale 1ns / 1ps

// html entity decoder, one raw message byte per input transaction
// input channel: in_byte, in_last with in_valid / in_ready
// output channel: out_byte, has_byte, out_last with out_valid / out_ready;
//   a bare end marker (has_byte low, out_last high) closes a message that
//   ends with no decoded byte
// config channel: cfg_data with cfg_valid / cfg_ready, always ready; sets the
//   output size limit, write only between messages or while idle
// a taken byte waits in the input register, is decoded from there into the
//   result buffer, and its results are offered from the result buffer
// throughput: one byte per cycle while each byte gives at most one result and
//   out_ready stays high; a transaction that releases k results holds the
//   single-read result buffer until all k are read, and input stalls meanwhile
// a stalled receiver holds the buffer, then the input register, then in_ready
//   falls; nothing is lost or reordered
// reset: limit returns to 128, no match in progress, buffers empty
module html_entity_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       out_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import hed_pkg::*;

	logic [7:0]                  limit_q;
	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        last_s1;
	hed_state_t                  state_q;
	hed_state_t                  state_nxt;
	logic [HOLD_DEPTH-1:0][7:0]  held_q;
	logic                        hold_wr;
	logic [2:0]                  hold_idx;
	hed_res_t                    res;
	logic                        buf_free;
	logic                        adv;

	assign cfg_ready = 1'b1;
	assign adv = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hold_wr)
			held_q[hold_idx] <= byte_s1;
	end

	hed_match u_match (
		.cur      (state_q),
		.held     (held_q),
		.limit    (limit_q),
		.byte_in  (byte_s1),
		.last_in  (last_s1),
		.nxt      (state_nxt),
		.hold_wr  (hold_wr),
		.hold_idx (hold_idx),
		.res      (res)
	);

	hed_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (res),
		.free      (buf_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last)
	);

`ifndef SYNTHESIS
	a_bare_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (out_last && (out_byte == 8'h00)))
		else $error("bare marker without out_last or with data");

	a_held_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cnt <= 3'(HOLD_DEPTH))
		else $error("held count beyond hold depth");

	a_live_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.cnt == 3'd0) == (state_q.live == '0))
		else $error("live patterns disagree with held count");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> ((state_q.cnt == 3'd0) && (state_q.emitted == 8'd0)))
		else $error("state not cleared after last transaction");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import hed_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		logic       has;
		logic       last;
	} dec_out_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} raw_in_t;

	class decode_scoreboard;
		int                 lim;
		logic [7:0]         held [HOLD_DEPTH];
		int                 held_cnt;
		logic [NUM_ENT-1:0] live;
		int                 emitted;
		int                 errors;
		dec_out_t           step_res [$];
		dec_out_t           decoded_q [$];

		function new();
			lim      = LIMIT_RESET;
			held_cnt = 0;
			live     = '0;
			emitted  = 0;
			errors   = 0;
		endfunction

		function void put_decoded(logic [7:0] b);
			int eff;
			dec_out_t r;
			eff = (lim > int'(LIMIT_MAX)) ? int'(LIMIT_MAX) : lim;
			if (emitted + 1 < eff && step_res.size() < RES_MAX) begin
				r.b    = b;
				r.has  = 1'b1;
				r.last = 1'b0;
				step_res.push_back(r);
				emitted++;
			end
		endfunction

		function void flush_held();
			for (int i = 0; i < held_cnt && i < HOLD_DEPTH; i++)
				put_decoded(held[i]);
			held_cnt = 0;
			live     = '0;
		endfunction

		function void start_or_pass(logic [7:0] b);
			if (b == AMP) begin
				held[0]  = b;
				held_cnt = 1;
				live     = LIVE_ALL;
			end else begin
				put_decoded(b);
			end
		endfunction

		// input transaction accepted: work out the decoded bytes it releases
		function void note_byte(logic [7:0] b, logic fin);
			int                 h;
			logic [NUM_ENT-1:0] nm;
			bit                 done;
			dec_out_t           r;
			step_res.delete();
			nm   = '0;
			done = 1'b0;
			h    = held_cnt;
			if (held_cnt == 0) begin
				start_or_pass(b);
			end else begin
				for (int p = 0; p < NUM_ENT; p++)
					if (live[p] && h < int'(ENT_LEN[p]) && ENT_TEXT[p][h] == b)
						nm[p] = 1'b1;
				if (nm != '0) begin
					for (int p = 0; p < NUM_ENT && !done; p++) begin
						if (nm[p] && int'(ENT_LEN[p]) == h + 1) begin
							put_decoded(ENT_REPL[p]);
							held_cnt = 0;
							live     = '0;
							done     = 1'b1;
						end
					end
					if (!done) begin
						if (h < HOLD_DEPTH) begin
							held[h]  = b;
							held_cnt = h + 1;
							live     = nm;
						end else begin
							flush_held();
							start_or_pass(b);
						end
					end
				end else begin
					flush_held();
					start_or_pass(b);
				end
			end
			if (fin) begin
				flush_held();
				if (step_res.size() > 0) begin
					r      = step_res.pop_back();
					r.last = 1'b1;
					step_res.push_back(r);
				end else begin
					r.b    = 8'h00;
					r.has  = 1'b0;
					r.last = 1'b1;
					step_res.push_back(r);
				end
				emitted = 0;
			end
			foreach (step_res[i])
				decoded_q.push_back(step_res[i]);
		endfunction

		task report(string what);
			errors++;
			$display("%0t mismatch: %s", $time, what);
		endtask

		task check_decoded(logic [7:0] b, logic hb, logic fin);
			dec_out_t e;
			if (decoded_q.size() == 0) begin
				report($sformatf("unexpected result byte=%02h has=%0b last=%0b", b, hb, fin));
				return;
			end
			e = decoded_q.pop_front();
			if (b !== e.b)
				report($sformatf("out_byte %02h, want %02h", b, e.b));
			if (hb !== e.has)
				report($sformatf("has_byte %0b, want %0b", hb, e.has));
			if (fin !== e.last)
				report($sformatf("out_last %0b, want %0b", fin, e.last));
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       out_last;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;

	bit               calm = 1'b0;
	int               quiet_cycles = 0;
	raw_in_t          stim_q [$];
	decode_scoreboard sb;

	html_entity_decoder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.has_byte  (has_byte),
		.out_last  (out_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 23);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_decoded(out_byte, has_byte, out_last);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == 2000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic void push_byte(logic [7:0] b, logic fin);
		raw_in_t it;
		it.b    = b;
		it.last = fin;
		stim_q.push_back(it);
	endfunction

	function automatic void push_text(string s, logic fin);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], fin && (i == s.len() - 1));
	endfunction

	function automatic void close_message();
		raw_in_t it;
		it      = stim_q.pop_back();
		it.last = 1'b1;
		stim_q.push_back(it);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(32, 126));
		if (c == AMP)
			c = "a";
		return c;
	endfunction

	// mostly entities, near misses and entity letters, some raw noise
	function automatic void add_message(int tokens);
		string alpha = "&&#;0139ntlgqampsbuo";
		int    k;
		int    e;
		int    n;
		for (int t = 0; t < tokens; t++) begin
			k = $urandom_range(99);
			e = $urandom_range(NUM_ENT - 1);
			if (k < 35) begin
				push_byte(plain_char(), 1'b0);
			end else if (k < 60) begin
				for (int i = 0; i < int'(ENT_LEN[e]); i++)
					push_byte(ENT_TEXT[e][i], 1'b0);
			end else if (k < 75) begin
				n = $urandom_range(1, int'(ENT_LEN[e]) - 1);
				for (int i = 0; i < n; i++)
					push_byte(ENT_TEXT[e][i], 1'b0);
			end else if (k < 85) begin
				push_byte(8'($urandom_range(255)), 1'b0);
			end else begin
				push_byte(alpha[$urandom_range(alpha.len() - 1)], 1'b0);
			end
		end
		close_message();
	endfunction

	function automatic void fill_random(int n);
		while (stim_q.size() < n)
			add_message($urandom_range(1, 8));
	endfunction

	task automatic set_limit(logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.lim = v;
	endtask

	task automatic send_all();
		raw_in_t it;
		while (stim_q.size() != 0) begin
			it = stim_q.pop_front();
			while (!calm && $urandom_range(99) < 23) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte  <= it.b;
			in_last  <= it.last;
			do @(posedge clk); while (!in_ready);
			sb.note_byte(it.b, it.last);
		end
		in_valid <= 1'b0;
	endtask

	task automatic play();
		send_all();
		while (sb.decoded_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit: entity forms, breaks, data extremes, flushes at the end
		push_text("&#039;&a&lt;", 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_text("&quot", 1'b1);
		push_text("&", 1'b1);
		push_text("&nbspX", 1'b1);
		fill_random(35);
		play();

		set_limit(8'd1);
		fill_random(6);
		play();

		set_limit(8'd0);
		fill_random(5);
		play();

		set_limit(8'd6);
		fill_random(10);
		play();

		set_limit(8'd2);
		fill_random(6);
		play();

		set_limit(8'($urandom_range(3, 40)));
		fill_random(12);
		play();

		// no idling: one message that runs into the largest limit
		calm = 1'b1;
		set_limit(8'd255);
		for (int i = 0; i < 255; i++)
			push_byte(plain_char(), 1'b0);
		close_message();
		play();

		repeat (10) @(posedge clk);
		if (sb.decoded_q.size() != 0)
			sb.report("results still expected at end of run");
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/hed_pkg.sv
sv/hed_match.sv
sv/hed_outbuf.sv
sv/html_entity_decoder_unit.sv
test/tb_top.sv
